FILE: design/sc2a_pkg.sv
// Shared types, constants and key tables for the scan code to ASCII FIFO.
// Set 1 scan codes, US layout. No dependencies.
package sc2a_pkg;

  // FIFO geometry
  localparam int unsigned FIFO_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Request kinds on the input tuser bit
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Modifier scan codes (make codes, bit 7 clear)
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_LCTRL  = 7'h1D;
  localparam logic [6:0] SC_LALT   = 7'h38;
  localparam logic [6:0] SC_CAPS   = 7'h3A;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } flags_t;

  // Per-request status carried down the pipeline
  typedef struct packed {
    logic   read_valid;
    logic   dropped;
    logic   has_input;
    flags_t flags;
  } res_t;

  // Key table: returns {shifted, plain}; zero means no character
  function automatic logic [15:0] key_chars(input logic [6:0] code);
    logic [15:0] r;
    case (code)
      7'h01: r = {8'd27, 8'd27};
      7'h02: r = {"!", "1"};  7'h03: r = {"@", "2"};  7'h04: r = {"#", "3"};
      7'h05: r = {"$", "4"};  7'h06: r = {"%", "5"};  7'h07: r = {"^", "6"};
      7'h08: r = {"&", "7"};  7'h09: r = {"*", "8"};  7'h0A: r = {"(", "9"};
      7'h0B: r = {")", "0"};  7'h0C: r = {"_", "-"};  7'h0D: r = {"+", "="};
      7'h0E: r = {8'd8, 8'd8};
      7'h0F: r = {8'd9, 8'd9};
      7'h10: r = {"Q", "q"};  7'h11: r = {"W", "w"};  7'h12: r = {"E", "e"};
      7'h13: r = {"R", "r"};  7'h14: r = {"T", "t"};  7'h15: r = {"Y", "y"};
      7'h16: r = {"U", "u"};  7'h17: r = {"I", "i"};  7'h18: r = {"O", "o"};
      7'h19: r = {"P", "p"};  7'h1A: r = {"{", "["};  7'h1B: r = {"}", "]"};
      7'h1C: r = {8'd10, 8'd10};
      7'h1E: r = {"A", "a"};  7'h1F: r = {"S", "s"};  7'h20: r = {"D", "d"};
      7'h21: r = {"F", "f"};  7'h22: r = {"G", "g"};  7'h23: r = {"H", "h"};
      7'h24: r = {"J", "j"};  7'h25: r = {"K", "k"};  7'h26: r = {"L", "l"};
      7'h27: r = {":", ";"};
      7'h28: r = {8'h22, 8'h27};
      7'h29: r = {8'h7E, 8'h60};
      7'h2B: r = {8'h7C, 8'h5C};
      7'h2C: r = {"Z", "z"};  7'h2D: r = {"X", "x"};  7'h2E: r = {"C", "c"};
      7'h2F: r = {"V", "v"};  7'h30: r = {"B", "b"};  7'h31: r = {"N", "n"};
      7'h32: r = {"M", "m"};  7'h33: r = {"<", ","};  7'h34: r = {">", "."};
      7'h35: r = {"?", "/"};  7'h37: r = {"*", "*"};  7'h39: r = {" ", " "};
      7'h47: r = {"7", "7"};  7'h48: r = {"8", "8"};  7'h49: r = {"9", "9"};
      7'h4A: r = {"-", "-"};  7'h4B: r = {"4", "4"};  7'h4C: r = {"5", "5"};
      7'h4D: r = {"6", "6"};  7'h4E: r = {"+", "+"};  7'h4F: r = {"1", "1"};
      7'h50: r = {"2", "2"};  7'h51: r = {"3", "3"};  7'h52: r = {"0", "0"};
      7'h53: r = {".", "."};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/sc2a_keymap.sv
// Scan code decoder: modifier tracking and translation to ASCII.
// Depends on sc2a_pkg for the key table and flag type.
module sc2a_keymap (
  input  logic [7:0]      scan_code_i,
  input  sc2a_pkg::flags_t flags_i,
  output sc2a_pkg::flags_t flags_o,
  output logic [7:0]      char_o,
  output logic            char_vld_o
);
  import sc2a_pkg::*;

  logic [6:0]  code;
  logic        release_key;
  logic [15:0] chars;
  logic        is_letter;
  logic        take_shifted;

  assign code        = scan_code_i[6:0];
  assign release_key = scan_code_i[7];
  assign chars       = key_chars(code);
  assign is_letter   = (chars[7:0] >= "a") && (chars[7:0] <= "z");

  // Caps lock inverts the shift choice for letters only
  assign take_shifted = flags_i.shift ^ (flags_i.caps && is_letter);

  always_comb begin
    flags_o    = flags_i;
    char_o     = '0;
    char_vld_o = 1'b0;
    if (release_key) begin
      // Release: drop the matching modifier, ignore everything else
      if (code == SC_LSHIFT || code == SC_RSHIFT) flags_o.shift = 1'b0;
      if (code == SC_LCTRL) flags_o.ctrl = 1'b0;
      if (code == SC_LALT)  flags_o.alt  = 1'b0;
    end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      flags_o.shift = 1'b1;
    end else if (code == SC_LCTRL) begin
      flags_o.ctrl = 1'b1;
    end else if (code == SC_LALT) begin
      flags_o.alt = 1'b1;
    end else if (code == SC_CAPS) begin
      flags_o.caps = ~flags_i.caps;
    end else begin
      // Plain key: look up character, zero means unmapped
      char_o     = take_shifted ? chars[15:8] : chars[7:0];
      char_vld_o = (char_o != 8'd0);
    end
  end

endmodule

FILE: design/scan_code_to_ascii_fifo_top.sv
// Top level: scan code to ASCII translator with a character FIFO.
// A result passes stage A (request status, memory read), then the stage B output register,
// before it goes valid on the master side. Throughput: one request per cycle while the
// output is not stalled; the FIFO memory takes one write or one read per cycle.
// Reset clears the modifier flags, caps latch, FIFO pointers and pipeline valids at once;
// the character memory is not cleared and needs no clearing pass.
// Depends on sc2a_pkg and sc2a_keymap.
module scan_code_to_ascii_fifo_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scan_code
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_char, [8] char_dropped, [9] has_input, [10] shift_held,
  // [11] ctrl_held, [12] alt_held, [13] caps_on, [15:14] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] read_valid
);
  import sc2a_pkg::*;

  // Pointers and flags
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_inc, rd_ptr_inc;
  flags_t           flags_q, flags_d, key_flags;
  logic [7:0]       key_char;
  logic             key_vld;

  // Request handling
  logic acc, is_read, not_empty, full, push, wr_en, rd_en, drop;

  // Memory and pipeline
  logic [7:0]  char_mem [FIFO_DEPTH];
  logic [7:0]  rd_data_q;
  logic        valid_a_q, valid_b_q;
  res_t        res_a_q, res_a_d;
  logic        a_adv;
  logic [15:0] data_b_q;
  logic        user_b_q;
  logic [7:0]  char_a;

  sc2a_keymap u_keymap (
    .scan_code_i (s_axis_tdata),
    .flags_i     (flags_q),
    .flags_o     (key_flags),
    .char_o      (key_char),
    .char_vld_o  (key_vld)
  );

  // Handshake: stage A moves on when the output register is free or taken
  assign a_adv         = !valid_b_q || m_axis_tready;
  assign s_axis_tready = !valid_a_q || a_adv;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign is_read       = (s_axis_tuser == CMD_READ);

  // FIFO status, one slot kept free
  assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
  assign not_empty  = (rd_ptr_q != wr_ptr_q);
  assign full       = (wr_ptr_inc == rd_ptr_q);

  assign push  = acc && !is_read && key_vld;
  assign wr_en = push && !full;
  assign drop  = push && full;
  assign rd_en = acc && is_read && not_empty;

  assign wr_ptr_d = wr_en ? wr_ptr_inc : wr_ptr_q;
  assign rd_ptr_d = rd_en ? rd_ptr_inc : rd_ptr_q;
  assign flags_d  = (acc && !is_read) ? key_flags : flags_q;

  // Status of the request after its update
  always_comb begin
    res_a_d.read_valid = rd_en;
    res_a_d.dropped    = drop;
    res_a_d.has_input  = (wr_ptr_d != rd_ptr_d);
    res_a_d.flags      = flags_d;
  end

  // Advance pointers and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      flags_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      flags_q  <= flags_d;
    end
  end

  // Character memory: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      char_mem[wr_ptr_q] <= key_char;
    end
    if (rd_en) begin
      rd_data_q <= char_mem[rd_ptr_q];
    end
  end

  // Stage A: hold request status while the memory read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_a_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_a_q <= res_a_d;
    end
  end

  assign char_a = res_a_q.read_valid ? rd_data_q : 8'd0;

  // Stage B: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (a_adv) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && valid_a_q) begin
      data_b_q <= {2'b00, res_a_q.flags.caps, res_a_q.flags.alt, res_a_q.flags.ctrl,
                   res_a_q.flags.shift, res_a_q.has_input, res_a_q.dropped, char_a};
      user_b_q <= res_a_q.read_valid;
    end
  end

  assign m_axis_tvalid = valid_b_q;
  assign m_axis_tdata  = data_b_q;
  assign m_axis_tuser  = user_b_q;

`ifndef SYNTHESIS
  // Stalled stage A keeps its read data
  a_hold_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_a_q && res_a_q.read_valid && !a_adv) |=> (valid_a_q && $stable(rd_data_q)))
    else $error("stage A lost its read data while stalled");

  // A pop advances the read pointer by exactly one slot
  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (rd_ptr_q == $past(rd_ptr_inc)))
    else $error("read pointer did not advance on pop");

  // A free output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_b_q |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // A read never reports a dropped character
  a_read_nodrop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_a_q && res_a_q.read_valid) |-> !res_a_q.dropped)
    else $error("read result flagged as dropped");
`endif

endmodule

FILE: bench/scan_ascii_checker.sv
// Checker for scan_code_to_ascii_fifo_top: watches both stream sides, predicts
// the status word of every accepted request, and compares results in order.
// Depends on sc2a_pkg for the request kinds, the modifier codes and FIFO_DEPTH.
module scan_ascii_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,    // [7:0] scan_code
  input  logic        s_tuser_i,    // [0] command
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [7:0] read_char, [8] char_dropped, [9] has_input, [10] shift_held,
  // [11] ctrl_held, [12] alt_held, [13] caps_on, [15:14] zero
  input  logic [15:0] m_tdata_i,
  input  logic        m_tuser_i,    // [0] read_valid
  output int          errors_o,
  output int          pending_o,
  output int          pops_o,
  output int          empty_reads_o,
  output int          drops_o,
  output int          peak_fill_o
);
  import sc2a_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       dropped;
    logic       has_input;
    logic       shift;
    logic       ctrl;
    logic       alt;
    logic       caps;
  } key_status_t;

  // US layout key maps, unshifted and shifted; zero means no character
  logic [7:0]  plain_map   [128];
  logic [7:0]  shifted_map [128];

  // Predicted keyboard state and buffer contents
  logic        kb_shift;
  logic        kb_ctrl;
  logic        kb_alt;
  logic        kb_caps;
  logic [7:0]  typed_chars [$];
  key_status_t status_q    [$];

  int mismatch_count;
  int result_count;
  int pop_count;
  int empty_read_count;
  int drop_count;
  int peak_fill;

  task automatic map_key(input logic [6:0] code, input logic [7:0] plain,
                         input logic [7:0] shifted);
    plain_map[code]   = plain;
    shifted_map[code] = shifted;
  endtask

  // Build the key maps
  initial begin
    string digits_plain;
    string digits_shift;
    string row_q;
    string row_a;
    string row_z;
    string keypad;
    digits_plain = "1234567890";
    digits_shift = "!@#$%^&*()";
    row_q        = "qwertyuiop";
    row_a        = "asdfghjkl";
    row_z        = "zxcvbnm";
    keypad       = "789-456+1230.";
    for (int i = 0; i < 128; i++) begin
      plain_map[i]   = 8'h00;
      shifted_map[i] = 8'h00;
    end
    for (int i = 0; i < digits_plain.len(); i++)
      map_key(7'(8'h02 + i), digits_plain[i], digits_shift[i]);
    for (int i = 0; i < row_q.len(); i++) map_key(7'(8'h10 + i), row_q[i], row_q[i] - 8'h20);
    for (int i = 0; i < row_a.len(); i++) map_key(7'(8'h1E + i), row_a[i], row_a[i] - 8'h20);
    for (int i = 0; i < row_z.len(); i++) map_key(7'(8'h2C + i), row_z[i], row_z[i] - 8'h20);
    for (int i = 0; i < keypad.len(); i++) map_key(7'(8'h47 + i), keypad[i], keypad[i]);
    map_key(7'h01, 8'h1B, 8'h1B);
    map_key(7'h0C, "-", "_");     map_key(7'h0D, "=", "+");
    map_key(7'h0E, 8'h08, 8'h08); map_key(7'h0F, 8'h09, 8'h09);
    map_key(7'h1A, "[", "{");     map_key(7'h1B, "]", "}");
    map_key(7'h1C, 8'h0A, 8'h0A);
    map_key(7'h27, ";", ":");     map_key(7'h28, 8'h27, 8'h22);
    map_key(7'h29, 8'h60, 8'h7E); map_key(7'h2B, 8'h5C, 8'h7C);
    map_key(7'h33, ",", "<");     map_key(7'h34, ".", ">");
    map_key(7'h35, "/", "?");     map_key(7'h37, "*", "*");
    map_key(7'h39, " ", " ");
  end

  // Advance the keyboard and buffer state by one request, return its status
  function automatic key_status_t apply_request(input logic cmd, input logic [7:0] code);
    key_status_t r;
    logic [7:0]  base;
    logic [7:0]  ch;
    logic        pick_upper;
    r = '0;
    if (cmd == CMD_READ) begin
      if (typed_chars.size() != 0) begin
        r.ch    = typed_chars.pop_front();
        r.valid = 1'b1;
        pop_count++;
      end else begin
        empty_read_count++;
      end
    end else if (code[7]) begin
      // key up: only the held modifiers care
      if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT) kb_shift = 1'b0;
      if (code[6:0] == SC_LCTRL) kb_ctrl = 1'b0;
      if (code[6:0] == SC_LALT)  kb_alt  = 1'b0;
    end else if (code[6:0] == SC_LSHIFT || code[6:0] == SC_RSHIFT) begin
      kb_shift = 1'b1;
    end else if (code[6:0] == SC_LCTRL) begin
      kb_ctrl = 1'b1;
    end else if (code[6:0] == SC_LALT) begin
      kb_alt = 1'b1;
    end else if (code[6:0] == SC_CAPS) begin
      kb_caps = !kb_caps;
    end else begin
      // caps lock flips the shift choice for letters only
      base       = plain_map[code[6:0]];
      pick_upper = kb_shift;
      if (kb_caps && base >= "a" && base <= "z") pick_upper = !pick_upper;
      ch = pick_upper ? shifted_map[code[6:0]] : base;
      if (ch != 8'h00) begin
        if (typed_chars.size() >= FIFO_DEPTH - 1) begin
          r.dropped = 1'b1;
          drop_count++;
        end else begin
          typed_chars.push_back(ch);
          if (typed_chars.size() > peak_fill) peak_fill = typed_chars.size();
        end
      end
    end
    r.has_input = (typed_chars.size() != 0);
    r.shift     = kb_shift;
    r.ctrl      = kb_ctrl;
    r.alt       = kb_alt;
    r.caps      = kb_caps;
    return r;
  endfunction

  function automatic string describe(input key_status_t s);
    return $sformatf("char %02h valid %b dropped %b input %b shift %b ctrl %b alt %b caps %b",
                     s.ch, s.valid, s.dropped, s.has_input, s.shift, s.ctrl, s.alt, s.caps);
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    key_status_t got;
    key_status_t want;
    if (!rst_ni) begin
      kb_shift         = 1'b0;
      kb_ctrl          = 1'b0;
      kb_alt           = 1'b0;
      kb_caps          = 1'b0;
      typed_chars.delete();
      status_q.delete();
      mismatch_count   = 0;
      result_count     = 0;
      pop_count        = 0;
      empty_read_count = 0;
      drop_count       = 0;
      peak_fill        = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) status_q.push_back(apply_request(s_tuser_i, s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.ch        = m_tdata_i[7:0];
        got.valid     = m_tuser_i;
        got.dropped   = m_tdata_i[8];
        got.has_input = m_tdata_i[9];
        got.shift     = m_tdata_i[10];
        got.ctrl      = m_tdata_i[11];
        got.alt       = m_tdata_i[12];
        got.caps      = m_tdata_i[13];
        if (status_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result %0d arrived with nothing expected: %s", result_count, describe(got));
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch on result %0d", result_count);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
        result_count++;
      end
    end
    errors_o      <= mismatch_count;
    pending_o     <= status_q.size();
    pops_o        <= pop_count;
    empty_reads_o <= empty_read_count;
    drops_o       <= drop_count;
    peak_fill_o   <= peak_fill;
  end

endmodule

FILE: bench/scan_code_to_ascii_fifo_top_test.sv
// Testbench top for scan_code_to_ascii_fifo_top: drives scan codes and read
// requests with random bursts and stalls, and gives the verdict.
// Depends on sc2a_pkg, the block itself and scan_ascii_checker.
module scan_code_to_ascii_fifo_top_test;
  import sc2a_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_LIMIT   = 1000;

  // Plain keys used in the directed part
  localparam logic [6:0] KEY_BLANK = 7'h00;
  localparam logic [6:0] KEY_ESC   = 7'h01;
  localparam logic [6:0] KEY_1     = 7'h02;
  localparam logic [6:0] KEY_Q     = 7'h10;
  localparam logic [6:0] KEY_A     = 7'h1E;
  localparam logic [6:0] KEY_F1    = 7'h3B;
  localparam logic [6:0] KEY_TOP   = 7'h7F;

  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_WINDOW, READY_MOSTLY} ready_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = CMD_SCAN;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int errors;
  int pending;
  int pops;
  int empty_reads;
  int drops;
  int peak_fill;

  int          sent = 0;
  int          directed_count = 0;
  int          burst_left = 0;
  logic        steady = 1'b0;
  int          idle_cycles = 0;
  int          ready_cycle = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  scan_code_to_ascii_fifo_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  scan_ascii_checker status_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .errors_o      (errors),
    .pending_o     (pending),
    .pops_o        (pops),
    .empty_reads_o (empty_reads),
    .drops_o       (drops),
    .peak_fill_o   (peak_fill)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side on a pattern redrawn when ready_cycle[7:0] is zero
  always @(posedge clk_i) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle[7:0] == 8'h00) ready_mode <= ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS: m_axis_tready <= 1'b1;
      READY_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      READY_WINDOW: m_axis_tready <= (ready_cycle[2:0] < 3'd2);
      default:      m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // End the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles, %0d results pending",
               IDLE_LIMIT, pending);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] key_down(input logic [6:0] code);
    return {1'b0, code};
  endfunction

  function automatic logic [7:0] key_up(input logic [6:0] code);
    return {1'b1, code};
  endfunction

  function automatic logic [6:0] pick_modifier();
    case ($urandom_range(0, 3))
      0:       return SC_LSHIFT;
      1:       return SC_RSHIFT;
      2:       return SC_LCTRL;
      default: return SC_LALT;
    endcase
  endfunction

  // Offer one request and hold it until accepted; open a new burst when due
  task automatic push_request(input logic cmd, input logic [7:0] code);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= code;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Typing session: reads, modifier traffic, key presses with or without key up
  task automatic key_session(input int count, input int read_pct, input int noise_pct);
    int         stop_at;
    int         pick;
    logic [6:0] key;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      key  = 7'($urandom_range(1, 8'h53));
      if (pick < noise_pct) begin
        push_request(logic'($urandom_range(0, 1)), 8'($urandom));
      end else if (pick < noise_pct + read_pct) begin
        push_request(CMD_READ, 8'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: push_request(CMD_SCAN, key_down(pick_modifier()));
          3, 4, 5: push_request(CMD_SCAN, key_up(pick_modifier()));
          6: begin
            push_request(CMD_SCAN, key_down(SC_CAPS));
            if ($urandom_range(0, 1) == 1) push_request(CMD_SCAN, key_up(SC_CAPS));
          end
          default: begin
            push_request(CMD_SCAN, key_down(key));
            if ($urandom_range(0, 1) == 1) push_request(CMD_SCAN, key_up(key));
          end
        endcase
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty read, unmapped codes, modifiers, shared shift, caps rules
    push_request(CMD_READ, 8'hFF);
    push_request(CMD_SCAN, key_down(KEY_BLANK));
    push_request(CMD_SCAN, key_up(KEY_TOP));
    push_request(CMD_SCAN, key_down(KEY_A));
    push_request(CMD_SCAN, key_down(SC_LSHIFT));
    push_request(CMD_SCAN, key_down(KEY_A));
    push_request(CMD_SCAN, key_up(SC_RSHIFT));
    push_request(CMD_SCAN, key_down(SC_RSHIFT));
    push_request(CMD_SCAN, key_down(KEY_1));
    push_request(CMD_SCAN, key_up(SC_LSHIFT));
    push_request(CMD_SCAN, key_down(SC_LCTRL));
    push_request(CMD_SCAN, key_down(SC_LALT));
    push_request(CMD_SCAN, key_down(KEY_F1));
    push_request(CMD_SCAN, key_up(SC_LCTRL));
    push_request(CMD_SCAN, key_up(SC_LALT));
    push_request(CMD_SCAN, key_down(SC_CAPS));
    push_request(CMD_SCAN, key_down(KEY_Q));
    push_request(CMD_SCAN, key_down(KEY_1));
    push_request(CMD_SCAN, key_up(SC_CAPS));
    push_request(CMD_SCAN, key_down(SC_LSHIFT));
    push_request(CMD_SCAN, key_down(KEY_Q));
    push_request(CMD_SCAN, key_up(SC_LSHIFT));
    push_request(CMD_SCAN, key_down(SC_CAPS));
    push_request(CMD_SCAN, key_down(KEY_ESC));
    push_request(CMD_READ, 8'h00);
    push_request(CMD_READ, 8'h5A);
    directed_count = sent;
    wait_for_drain();

    // Mixed typing, then overfill the buffer and read it dry
    key_session(200, 35, 5);
    repeat (330) push_request(CMD_SCAN, key_down(7'($urandom_range(8'h10, 8'h32))));
    repeat (280) push_request(CMD_READ, 8'($urandom));
    wait_for_drain();

    // Sessions of varied read density, some without sender gaps
    while (sent < directed_count + RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       key_session($urandom_range(60, 150), 15, 10);
        1:       key_session($urandom_range(60, 150), 35, 5);
        default: key_session($urandom_range(60, 150), 55, 10);
      endcase
      if ($urandom_range(0, 2) == 0) wait_for_drain();
    end
    steady = 1'b0;

    wait_for_drain();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests (%0d directed): %0d characters read back, %0d empty reads.",
             sent, directed_count, pops, empty_reads);
    $display("Buffer reached %0d of %0d bytes; %0d characters lost while it was full.",
             peak_fill, FIFO_DEPTH - 1, drops);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
